// File: sv/kdpc_pkg.sv
// kdpc_pkg: shared constants for the key debounce press classifier
// phase codes, debounce masks, register indexes and register reset values
// no dependencies

package kdpc_pkg;

    localparam int MASK_W  = 8;
    localparam int COUNT_W = 8;
    localparam int PHASE_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // history mask patterns for a debounced press and a debounced release
    localparam logic [MASK_W-1:0] MASK_PRESS   = 8'h7f;
    localparam logic [MASK_W-1:0] MASK_RELEASE = 8'h01;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_NONE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PRESS   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SHORT   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LONG    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONT_LONG  = 1'd1;

    // configuration reset values
    localparam logic [COUNT_W-1:0] LONG_TICKS_RESET = 8'd200;
    localparam logic               CONT_LONG_RESET  = 1'b0;

endpackage

// File: sv/key_debounce_press_classifier.sv
// key_debounce_press_classifier: debounce of an active-low key with short/long press events
// uses kdpc_pkg for phase codes, masks and register indexes
// single module with one result register stage

// Usage
// in channel: one transaction per scan tick, carrying the sampled pin level
//   (0 = pressed); accepted when in_valid is high and in_stall is low
// out channel: one transaction per accepted tick with short_event and
//   long_event; taken when out_valid is high and out_stall is low
// cfg channel: cfg_index selects the register (0 long_press_ticks,
//   1 continuous_long), cfg_data carries the value; cfg_ready is always high,
//   write only while the block is idle
// result: each tick's result is registered and is on the out port in the
//   cycle after the tick is accepted
// throughput: one tick per cycle unless the held result is stalled; the debounce and phase
//   update is one pass of logic from the current state into the state and result registers
// stall: the result register holds its transaction while out_stall is high;
//   in_stall rises only while a held result is stalled, and a new tick is
//   taken in the same cycle the held result leaves
// reset: history mask, phase and hold count clear to zero (no press), the
//   threshold returns to 200 and continuous mode to off, no result is pending

module key_debounce_press_classifier
(
    input  logic                               clk,
    input  logic                               rst_n,
    // tick input
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               level,
    // event output
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               short_event,
    output logic                               long_event,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kdpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kdpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration registers
    logic [kdpc_pkg::COUNT_W-1:0] long_ticks_reg;
    logic                         cont_long_reg;

    // tracking state
    logic [kdpc_pkg::MASK_W-1:0]  mask_reg,  mask_next;
    logic [kdpc_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [kdpc_pkg::COUNT_W-1:0] count_reg, count_next;

    // result register
    logic out_valid_reg;
    logic short_reg, short_next;
    logic long_reg,  long_next;

    logic                         accept;
    logic                         low;
    logic [kdpc_pkg::MASK_W-1:0]  mask_mid;
    logic [kdpc_pkg::PHASE_W-1:0] phase_mid;
    logic [kdpc_pkg::COUNT_W-1:0] count_inc;

    // the result register frees up when its transaction is taken
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign short_event = short_reg;
    assign long_event  = long_reg;

    // debounce: set bit 0 and shift left on a low level, shift right on a high one
    assign low       = !level;
    assign mask_mid  = low ? (mask_reg | kdpc_pkg::MASK_RELEASE) : (mask_reg >> 1);
    assign count_inc = count_reg + kdpc_pkg::COUNT_W'(1);

    always_comb
    begin
        mask_next = low ? {mask_mid[kdpc_pkg::MASK_W-2:0], 1'b0} : mask_mid;

        // a debounced edge overrides the current phase
        phase_mid = phase_reg;
        if (low && mask_mid == kdpc_pkg::MASK_PRESS)
        begin
            phase_mid = kdpc_pkg::PH_PRESS;
        end
        else if (!low && mask_mid == kdpc_pkg::MASK_RELEASE)
        begin
            phase_mid = kdpc_pkg::PH_RELEASE;
        end

        phase_next = phase_mid;
        count_next = count_reg;
        short_next = 1'b0;
        long_next  = 1'b0;

        unique case (phase_mid)
            kdpc_pkg::PH_PRESS:
            begin
                phase_next = kdpc_pkg::PH_SHORT;
            end
            kdpc_pkg::PH_SHORT:
            begin
                if (low)
                begin
                    count_next = count_inc;
                    if (count_inc > long_ticks_reg)
                    begin
                        phase_next = kdpc_pkg::PH_LONG;
                    end
                end
                else
                begin
                    // first high sample while held: short press
                    short_next = 1'b1;
                    phase_next = kdpc_pkg::PH_NONE;
                    count_next = '0;
                end
            end
            kdpc_pkg::PH_LONG:
            begin
                long_next = 1'b1;
                if (!cont_long_reg)
                begin
                    phase_next = kdpc_pkg::PH_NONE;
                    count_next = '0;
                end
            end
            kdpc_pkg::PH_RELEASE:
            begin
                phase_next = kdpc_pkg::PH_NONE;
                count_next = '0;
            end
            default:
            begin
                // no press, or a code that cannot arise: hold
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_ticks_reg <= kdpc_pkg::LONG_TICKS_RESET;
            cont_long_reg  <= kdpc_pkg::CONT_LONG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                kdpc_pkg::CFG_LONG_TICKS: long_ticks_reg <= cfg_data;
                kdpc_pkg::CFG_CONT_LONG:  cont_long_reg  <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // tracking state advances once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            phase_reg <= kdpc_pkg::PH_NONE;
            count_reg <= '0;
        end
        else if (accept)
        begin
            mask_reg  <= mask_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            short_reg <= short_next;
            long_reg  <= long_next;
        end
    end

endmodule

// File: sv/kdpc_checker.sv
// kdpc_checker: port-level checks for key_debounce_press_classifier
// no package dependencies; bound into the classifier module below

module kdpc_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic level,
    input logic out_valid,
    input logic out_stall,
    input logic short_event,
    input logic long_event
);

    // a stalled result transaction holds its events
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(short_event) && $stable(long_event))
        else $error("stalled result changed");

    // a tick never yields both events
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(short_event && long_event))
        else $error("short and long event together");

    // input back-pressure only comes from a stalled pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // every accepted tick shows a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted tick gave no result");

    // a short press is only recognized on a high sample
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !level |=> !short_event)
        else $error("short event on a low sample");

endmodule

bind key_debounce_press_classifier kdpc_checker u_kdpc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .level       (level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .short_event (short_event),
    .long_event  (long_event)
);

// File: tb/key_debounce_press_classifier_test.sv
`timescale 1ns / 1ps
// key_debounce_press_classifier_test: self-checking bench for the key debounce press classifier
// depends on kdpc_pkg and key_debounce_press_classifier; drives pin ticks, checks short/long events

module key_debounce_press_classifier_test;

    // one result transaction: the two press events of a tick
    typedef struct packed {
        logic short_ev;
        logic long_ev;
    } key_events_t;

    localparam int unsigned RANDOM_TICKS = 450;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // tick channel
    logic in_valid = 1'b0;
    logic in_stall;
    logic level = 1'b1;

    // event channel
    logic out_valid;
    logic out_stall = 1'b0;
    logic short_event;
    logic long_event;

    // register write channel
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [kdpc_pkg::CFG_IDX_W-1:0]  cfg_index = kdpc_pkg::CFG_LONG_TICKS;
    logic [kdpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // pin samples waiting to be driven, events waiting to come out
    logic        pending_levels[$];
    key_events_t expected_events[$];

    // predictor state, mirrors the block after reset
    logic [kdpc_pkg::MASK_W-1:0]  hist_mask = '0;
    logic [kdpc_pkg::PHASE_W-1:0] key_phase = kdpc_pkg::PH_NONE;
    logic [kdpc_pkg::COUNT_W-1:0] hold_cnt = '0;
    logic [kdpc_pkg::COUNT_W-1:0] long_thr = kdpc_pkg::LONG_TICKS_RESET;
    logic                         repeat_long = kdpc_pkg::CONT_LONG_RESET;

    // bookkeeping
    int unsigned err_count = 0;
    int unsigned n_queued = 0;
    int unsigned n_ticks = 0;
    int unsigned n_short = 0;
    int unsigned n_long = 0;
    int unsigned n_settings = 0;

    // driver and monitor pacing state
    int unsigned tick_gap = 0;
    int unsigned tick_quiet = 0;
    int unsigned stall_left = 0;
    int unsigned stall_quiet = 0;
    logic        drive_valid;
    logic        drive_stall;
    key_events_t seen_ev;
    key_events_t want_ev;

    key_debounce_press_classifier dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .level       (level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .short_event (short_event),
        .long_event  (long_event),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // debounce and classify one pin sample, advancing the predictor state
    function automatic key_events_t classify_tick(input logic pin);
        key_events_t ev;
        logic        pressed;
        ev = '0;
        pressed = (pin == 1'b0);
        // history mask: a press is seen on the way in, a release after the shift
        if (pressed)
        begin
            hist_mask = hist_mask | 8'h01;
            if (hist_mask == kdpc_pkg::MASK_PRESS)
                key_phase = kdpc_pkg::PH_PRESS;
            hist_mask = hist_mask << 1;
        end
        else
        begin
            hist_mask = hist_mask >> 1;
            if (hist_mask == kdpc_pkg::MASK_RELEASE)
                key_phase = kdpc_pkg::PH_RELEASE;
        end
        case (key_phase)
            kdpc_pkg::PH_PRESS:
                key_phase = kdpc_pkg::PH_SHORT;
            kdpc_pkg::PH_SHORT:
            begin
                // counter wraps at 8 bits, so a threshold of 255 never goes long
                hold_cnt = hold_cnt + 8'd1;
                if (pressed)
                begin
                    if (hold_cnt > long_thr)
                        key_phase = kdpc_pkg::PH_LONG;
                end
                else
                begin
                    ev.short_ev = 1'b1;
                    key_phase = kdpc_pkg::PH_NONE;
                    hold_cnt = '0;
                end
            end
            kdpc_pkg::PH_LONG:
            begin
                // continuous mode keeps firing until the release is debounced
                if (!repeat_long)
                begin
                    key_phase = kdpc_pkg::PH_NONE;
                    hold_cnt = '0;
                end
                ev.long_ev = 1'b1;
            end
            kdpc_pkg::PH_RELEASE:
            begin
                key_phase = kdpc_pkg::PH_NONE;
                hold_cnt = '0;
            end
            default:
                ;
        endcase
        return ev;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic got, input logic want);
        err_count++;
        $display("[%0t] mismatch on %s: got %0b, expected %0b (result %0d)",
                 $realtime, what, got, want, n_short + n_long);
    endtask

    // tick driver: one transaction per pin sample, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tick_gap = 0;
            tick_quiet = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_events.push_back(classify_tick(level));
                n_ticks++;
            end
            // a stalled transaction holds its payload
            if (!in_valid || !in_stall)
            begin
                drive_valid = 1'b0;
                if (tick_gap > 0)
                    tick_gap--;
                else if (pending_levels.size() > 0)
                begin
                    level <= pending_levels.pop_front();
                    drive_valid = 1'b1;
                    if (tick_quiet > 0)
                    begin
                        tick_quiet--;
                        tick_gap = 0;
                    end
                    else
                    begin
                        tick_gap = pick_gap();
                        // now and then a run of back-to-back ticks
                        if ($urandom_range(0, 63) == 0)
                            tick_quiet = $urandom_range(40, 120);
                    end
                end
                in_valid <= drive_valid;
            end
        end
    end

    // event monitor: compares each taken transaction with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            stall_quiet = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen_ev.short_ev = short_event;
                seen_ev.long_ev = long_event;
                if (seen_ev.short_ev === 1'b1)
                    n_short++;
                if (seen_ev.long_ev === 1'b1)
                    n_long++;
                if (expected_events.size() == 0)
                begin
                    err_count++;
                    $display("[%0t] event transaction with no tick pending", $realtime);
                end
                else
                begin
                    want_ev = expected_events.pop_front();
                    if (seen_ev.short_ev !== want_ev.short_ev)
                        report_mismatch("short_event", seen_ev.short_ev, want_ev.short_ev);
                    if (seen_ev.long_ev !== want_ev.long_ev)
                        report_mismatch("long_event", seen_ev.long_ev, want_ev.long_ev);
                end
            end
            // back-pressure: random stall bursts with quiet stretches between
            drive_stall = 1'b0;
            if (stall_left > 0)
            begin
                stall_left--;
                drive_stall = 1'b1;
            end
            else if (stall_quiet > 0)
                stall_quiet--;
            else
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    stall_left = pick_gap();
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        drive_stall = 1'b1;
                    end
                end
                if ($urandom_range(0, 199) == 0)
                    stall_quiet = $urandom_range(100, 300);
            end
            out_stall <= drive_stall;
        end
    end

    task automatic push_tick(input logic pin);
        pending_levels.push_back(pin);
        n_queued++;
    endtask

    task automatic push_run(input logic pin, input int unsigned count);
        repeat (count)
            push_tick(pin);
    endtask

    // one press with random content: bounce, hold, glitches, release, or plain pin noise
    task automatic push_press(input int unsigned span);
        int unsigned hold;
        if ($urandom_range(0, 99) < 12)
        begin
            // plain pin noise
            repeat ($urandom_range(1, 8))
                push_tick(1'($urandom_range(0, 1)));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                push_tick(1'($urandom_range(0, 1)));
        hold = 7 + $urandom_range(0, span + 12);
        if ($urandom_range(0, 4) == 0)
        begin
            // glitch high in the middle of the hold
            push_run(1'b0, hold / 2);
            push_tick(1'b1);
            push_run(1'b0, hold - hold / 2);
        end
        else
            push_run(1'b0, hold);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                push_tick(1'($urandom_range(0, 1)));
        // mostly a full release, sometimes cut short before the debounce
        if ($urandom_range(0, 9) == 0)
            push_run(1'b1, $urandom_range(1, 6));
        else
            push_run(1'b1, $urandom_range(7, 10));
    endtask

    // block must be idle before a register write
    task automatic wait_drain();
        while (pending_levels.size() > 0 || in_valid || expected_events.size() > 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [kdpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kdpc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == kdpc_pkg::CFG_LONG_TICKS)
            long_thr = data;
        else
            repeat_long = data[0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // new threshold and mode; upper data bits of the mode register are junk on purpose
    task automatic apply_setting(input logic [kdpc_pkg::COUNT_W-1:0] thr, input logic cont);
        wait_drain();
        write_reg(kdpc_pkg::CFG_LONG_TICKS, thr);
        write_reg(kdpc_pkg::CFG_CONT_LONG, {7'($urandom_range(0, 127)), cont});
        n_settings++;
    endtask

    initial
    begin : stimulus
        int unsigned random_start;
        int unsigned phase_end;
        int unsigned r;
        logic [kdpc_pkg::COUNT_W-1:0] thr;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: threshold 200, single long event
        n_settings = 1;
        push_run(1'b0, 7);   // press debounced on the seventh low
        push_tick(1'b1);     // first high while held gives a short press
        push_run(1'b1, 7);
        push_tick(1'b0);     // bounce that never debounces
        push_tick(1'b1);
        push_run(1'b0, 2);
        push_tick(1'b1);
        push_tick(1'b0);
        push_run(1'b1, 6);
        push_run(1'b0, 212); // long press past the reset threshold
        push_run(1'b1, 9);

        // threshold zero, continuous: long on the first held count, repeating
        apply_setting(8'd0, 1'b1);
        push_run(1'b0, 15);
        push_run(1'b1, 9);
        push_run(1'b0, 9);   // release cut short, then a fresh press
        push_run(1'b1, 2);
        push_run(1'b0, 4);
        push_run(1'b1, 9);

        // threshold 255: counter wraps, only a short press can come out
        apply_setting(8'd255, 1'b0);
        push_run(1'b0, 280);
        push_run(1'b1, 9);

        // threshold 254, continuous: long press just before the wrap
        apply_setting(8'd254, 1'b1);
        push_run(1'b0, 270);
        push_run(1'b1, 9);

        // threshold one, single shot
        apply_setting(8'd1, 1'b0);
        push_run(1'b0, 7);
        push_run(1'b1, 8);
        push_run(1'b0, 12);
        push_run(1'b1, 8);

        // random presses over a series of settings
        random_start = n_queued;
        while (n_queued - random_start < RANDOM_TICKS)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                thr = 8'd0;
            else if (r < 20)
                thr = 8'd255;
            else if (r < 30)
                thr = 8'($urandom_range(100, 254));
            else
                thr = 8'($urandom_range(1, 30));
            apply_setting(thr, 1'($urandom_range(0, 1)));
            phase_end = n_queued + $urandom_range(120, 200);
            while (n_queued < phase_end)
                push_press((thr > 40) ? 40 : thr);
        end

        wait_drain();
        repeat (5) @(posedge clk);

        $display("run covered %0d ticks over %0d threshold/mode settings",
                 n_ticks, n_settings);
        $display("observed %0d short and %0d long press events, %0d mismatches",
                 n_short, n_long, err_count);
        if (err_count == 0 && expected_events.size() == 0)
            $display("key_debounce_press_classifier_test: PASS");
        else
            $display("key_debounce_press_classifier_test: FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("watchdog expired with %0d events outstanding", expected_events.size());
        $display("key_debounce_press_classifier_test: FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/kdpc_pkg.sv
sv/key_debounce_press_classifier.sv
sv/kdpc_checker.sv
tb/key_debounce_press_classifier_test.sv
